// ===== sv/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared sizes, the input mode codes and the result record of the scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Pattern storage and window depth.
  localparam int MaxPattern = 64;
  // Number of hits after which the scan stops until a restart.
  localparam int HitLimit   = 8192;
  // Width of the saturating byte position counter.
  localparam int OffsetBits = 32;

  // Field widths fixed by the interface.
  localparam int ModeW      = 2;
  localparam int IndexW     = 6;
  localparam int ByteW      = 8;
  localparam int LengthW    = 7;
  localparam int HitOffsetW = 32;
  localparam int HitNumberW = 13;

  // Derived widths.
  localparam int PatIdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW    = $clog2(MaxPattern + 1);
  localparam int HitCntW = $clog2(HitLimit + 1);

  typedef enum logic [ModeW-1:0] {
    ModeLoad    = 2'd0,
    ModeData    = 2'd1,
    ModeRestart = 2'd2
  } mode_e;

  typedef logic [MaxPattern-1:0][ByteW-1:0] byte_vec_t;

  typedef struct packed {
    logic [HitOffsetW-1:0] hit_offset;
    logic [HitNumberW-1:0] hit_number;
    logic                  limit_reached;
  } result_t;

endpackage

// ===== sv/mbps_window_match.sv =====
// ----------------------------------------------------------------------------
// Masked window compare
// Aligns the newest bytes of the window with the pattern and checks every
// position in use against its value under its mask.
// ----------------------------------------------------------------------------
module mbps_window_match (
  input  mbps_pkg::byte_vec_t           window_i,  // index 0 is the newest byte
  input  mbps_pkg::byte_vec_t           value_i,
  input  mbps_pkg::byte_vec_t           mask_i,
  input  logic [mbps_pkg::LenW-1:0]     length_i,  // already limited to the depth
  output logic                          match_o
);

  localparam int FlatW = mbps_pkg::MaxPattern * mbps_pkg::ByteW;

  logic [FlatW-1:0]               oldest_first;
  logic [FlatW-1:0]               aligned;
  logic [mbps_pkg::LenW-1:0]      shift_len;
  logic [mbps_pkg::PatIdxW-1:0]   shift_amt;
  logic [mbps_pkg::MaxPattern-1:0] pos_ok;

  // Pattern position i meets the byte that arrived length-1-i bytes ago.
  // With the window laid out oldest first, that is a plain barrel shift.
  always_comb begin
    for (int i = 0; i < mbps_pkg::MaxPattern; i++) begin
      oldest_first[i*mbps_pkg::ByteW +: mbps_pkg::ByteW] =
        window_i[mbps_pkg::MaxPattern-1-i];
    end
  end

  assign shift_len = mbps_pkg::LenW'(mbps_pkg::MaxPattern) - length_i;
  assign shift_amt = shift_len[mbps_pkg::PatIdxW-1:0];
  assign aligned   = oldest_first >> {shift_amt, 3'b000};

  always_comb begin
    for (int i = 0; i < mbps_pkg::MaxPattern; i++) begin
      pos_ok[i] = (mbps_pkg::LenW'(i) >= length_i) ||
                  (((aligned[i*mbps_pkg::ByteW +: mbps_pkg::ByteW] ^ value_i[i]) &
                    mask_i[i]) == '0);
    end
  end

  assign match_o = (length_i != '0) && (&pos_ok);

endmodule

// ===== sv/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Searches a byte stream for a pattern of value/mask pairs and reports the
// start offset of every complete match, up to a fixed hit limit per buffer.
// ----------------------------------------------------------------------------
// Path: each item is held in the input register, then the compare stage
// writes any result into the output queue register that drives the ports.
// Throughput: one input item per cycle while the output side keeps up; the
// input stalls only while two results wait in the output queue.
// Reset: window, byte position, hit count and stop flag clear, the length
// register returns to one; pattern entries stay undefined until loaded.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [mbps_pkg::LengthW-1:0]      cfg_wdata_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mbps_pkg::ModeW-1:0]        mode_i,
  input  logic [mbps_pkg::IndexW-1:0]       entry_index_i,
  input  logic [mbps_pkg::ByteW-1:0]        entry_value_i,
  input  logic [mbps_pkg::ByteW-1:0]        entry_mask_i,
  input  logic [mbps_pkg::ByteW-1:0]        data_byte_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mbps_pkg::HitOffsetW-1:0]   hit_offset_o,
  output logic [mbps_pkg::HitNumberW-1:0]   hit_number_o,
  output logic                              limit_reached_o
);

  // Input register. The item waits here until the compare stage consumes it;
  // that stage also updates all scan state except the length register.
  logic                          in_valid_q;
  logic [mbps_pkg::ModeW-1:0]    mode_q;
  logic [mbps_pkg::IndexW-1:0]   index_q;
  logic [mbps_pkg::ByteW-1:0]    value_q;
  logic [mbps_pkg::ByteW-1:0]    mask_q;
  logic [mbps_pkg::ByteW-1:0]    data_q;

  // Scan state.
  logic [mbps_pkg::LengthW-1:0]    length_q;
  mbps_pkg::byte_vec_t             window_q;
  mbps_pkg::byte_vec_t             pat_value_q;
  mbps_pkg::byte_vec_t             pat_mask_q;
  logic [mbps_pkg::OffsetBits-1:0] pos_q;
  logic [mbps_pkg::HitCntW-1:0]    hits_q;
  logic                            stop_q;

  // Two-entry output queue; slot 0 is the head shown on the ports.
  mbps_pkg::result_t out_slot_q [2];
  logic [1:0]        out_count_q;

  logic                            fire;
  logic                            pop;
  logic                            push;
  logic                            is_data;
  logic                            match;
  mbps_pkg::byte_vec_t             window_shift;
  logic [mbps_pkg::LenW-1:0]       len_sat;
  logic [mbps_pkg::OffsetBits-1:0] pos_inc;
  logic [mbps_pkg::OffsetBits-1:0] start_pos;
  logic [mbps_pkg::HitCntW-1:0]    hits_inc;
  logic                            last_hit;
  mbps_pkg::result_t               result;

  // The compare stage runs whenever the queue has room for a possible result.
  // The input side never looks at the downstream ready, so one waiting result
  // does not hold up the input; only a full queue does.
  assign fire       = in_valid_q && (out_count_q != 2'd2);
  assign in_ready_o = !in_valid_q || fire;
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      index_q <= entry_index_i;
      value_q <= entry_value_i;
      mask_q  <= entry_mask_i;
      data_q  <= data_byte_i;
    end
  end

  // Lengths beyond the pattern depth behave as the full depth.
  assign len_sat = (length_q > mbps_pkg::LengthW'(mbps_pkg::MaxPattern)) ?
                   mbps_pkg::LenW'(mbps_pkg::MaxPattern) :
                   mbps_pkg::LenW'(length_q);

  // Window as it will be once the current data byte has entered.
  always_comb begin
    window_shift[0] = data_q;
    for (int k = 1; k < mbps_pkg::MaxPattern; k++) begin
      window_shift[k] = window_q[k-1];
    end
  end

  // The byte position sticks at its maximum; matching continues from there.
  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;

  mbps_window_match u_match (
    .window_i (window_shift),
    .value_i  (pat_value_q),
    .mask_i   (pat_mask_q),
    .length_i (len_sat),
    .match_o  (match)
  );

  // A data byte after the stop is dropped without touching any state.
  assign is_data   = (mode_q == mbps_pkg::ModeData) && !stop_q;
  assign push      = fire && is_data && match &&
                     (pos_inc >= mbps_pkg::OffsetBits'(len_sat));
  assign hits_inc  = hits_q + 1'b1;
  assign last_hit  = (hits_inc >= mbps_pkg::HitCntW'(mbps_pkg::HitLimit));
  assign start_pos = pos_inc - mbps_pkg::OffsetBits'(len_sat);

  assign result.hit_offset    = mbps_pkg::HitOffsetW'(start_pos);
  assign result.hit_number    = mbps_pkg::HitNumberW'(hits_q);
  assign result.limit_reached = last_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= mbps_pkg::LengthW'(1);
    end else if (cfg_we_i) begin
      length_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      pos_q    <= '0;
      hits_q   <= '0;
      stop_q   <= 1'b0;
    end else if (fire) begin
      case (mode_q)
        mbps_pkg::ModeData: begin
          if (!stop_q) begin
            window_q <= window_shift;
            pos_q    <= pos_inc;
            if (push) begin
              hits_q <= hits_inc;
              if (last_hit) begin
                stop_q <= 1'b1;
              end
            end
          end
        end
        mbps_pkg::ModeRestart: begin
          window_q <= '0;
          pos_q    <= '0;
          hits_q   <= '0;
          stop_q   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Pattern entries have no reset; loads take effect for the next data byte.
  always_ff @(posedge clk_i) begin
    if (fire && (mode_q == mbps_pkg::ModeLoad)) begin
      pat_value_q[index_q] <= value_q;
      pat_mask_q[index_q]  <= mask_q;
    end
  end

  // Output queue. A push only happens with a free slot, so a full queue
  // never sees one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_count_q <= 2'd0;
    end else if (push && !pop) begin
      out_count_q <= out_count_q + 2'd1;
    end else if (pop && !push) begin
      out_count_q <= out_count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && (out_count_q == 2'd1)) begin
        out_slot_q[0] <= result;
      end else begin
        out_slot_q[0] <= out_slot_q[1];
        if (push) begin
          out_slot_q[1] <= result;
        end
      end
    end else if (push) begin
      if (out_count_q == 2'd0) begin
        out_slot_q[0] <= result;
      end else begin
        out_slot_q[1] <= result;
      end
    end
  end

  assign out_valid_o     = (out_count_q != 2'd0);
  assign hit_offset_o    = out_slot_q[0].hit_offset;
  assign hit_number_o    = out_slot_q[0].hit_number;
  assign limit_reached_o = out_slot_q[0].limit_reached;

  // The queue never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q != 2'd3)
    else $error("output queue count out of range");

  // The hit that reaches the limit stops the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last_hit |=> stop_q)
    else $error("scan did not stop at the hit limit");

  // No result is produced while the scan is stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !push)
    else $error("result produced after the scan stopped");

  // A result never enters the queue while it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_count_q != 2'd2)
    else $error("result pushed into a full queue");

endmodule
